### hdl/bfs_pkg.sv
// ---------------------------------------------------------------------------
// bfs_pkg: shared types and constants for the bounded FIFO with statistics
// Sizes of the ring store, field widths, mode codes and the command and
// status words passed between controller and datapath.
// ---------------------------------------------------------------------------
package bfs_pkg;

   // ring store geometry
   localparam int DEPTH  = 1024;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   // field widths fixed by the interface
   localparam int DATA_W = 32;
   localparam int OCC_W  = 11;
   localparam int CNT_W  = 32;

   // width wide enough to compare the limit register against the fill count
   localparam int LIM_W  = (FILL_W > OCC_W) ? FILL_W : OCC_W;

   // item mode codes
   localparam logic MODE_ADD = 1'b0;
   localparam logic MODE_GET = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic take;   // item accepted this cycle: update state, read head
      logic load;   // load the result register
   } bfs_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_free;  // result register empty or being emptied
   } bfs_stat_type;

endpackage

### hdl/bfs_if.sv
// ---------------------------------------------------------------------------
// bfs_if: request and response channels
// Valid/ready channels carrying one request word and one response word.
// ---------------------------------------------------------------------------
interface bfs_req_if import bfs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     mode;
   logic signed [DATA_W-1:0] data_in;

   modport source (output valid, output mode, output data_in, input ready);
   modport sink   (input valid, input mode, input data_in, output ready);
endinterface

interface bfs_rsp_if import bfs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     accepted;
   logic signed [DATA_W-1:0] data_out;
   logic [OCC_W-1:0]         occupancy;
   logic [CNT_W-1:0]         add_tries;
   logic [CNT_W-1:0]         get_tries;
   logic [CNT_W-1:0]         adds_done;
   logic [CNT_W-1:0]         gets_done;

   modport source (output valid, output accepted, output data_out, output occupancy,
                   output add_tries, output get_tries, output adds_done,
                   output gets_done, input ready);
   modport sink   (input valid, input accepted, input data_out, input occupancy,
                   input add_tries, input get_tries, input adds_done,
                   input gets_done, output ready);
endinterface

### hdl/bfs_ctrl.sv
// ---------------------------------------------------------------------------
// bfs_ctrl: sequencing of request words
// Takes a request word, then waits for the result register to be free
// before loading the response and returning for the next word.
// ---------------------------------------------------------------------------
module bfs_ctrl import bfs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  bfs_stat_type stat,
   output bfs_cmd_type  cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_LOAD = 1'b1;

   logic state_ff;
   logic state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (stat.rsp_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/bfs_datapath.sv
// ---------------------------------------------------------------------------
// bfs_datapath: ring store, pointers, counters and result register
// Decides acceptance against fill and limit, updates the queue state on a
// taken word and builds the response word once the result register is free.
// ---------------------------------------------------------------------------
module bfs_datapath import bfs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  bfs_cmd_type              cmd,
   output bfs_stat_type             stat,
   input  logic                     req_mode,
   input  logic signed [DATA_W-1:0] req_data_in,
   input  logic                     csr_wr_en,
   input  logic [OCC_W-1:0]         csr_wr_data,
   bfs_rsp_if.source                rsp_chan
);

   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
   localparam logic [LIM_W-1:0] LIM_DEPTH = LIM_W'(DEPTH);
   localparam logic [OCC_W-1:0] LIM_RESET = OCC_W'(1024);

   // ring store and its registered read port
   logic [DATA_W-1:0] ring_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   logic [OCC_W-1:0]  limit_ff;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0]  add_try_ff, add_try_in;
   logic [CNT_W-1:0]  get_try_ff, get_try_in;
   logic [CNT_W-1:0]  add_done_ff, add_done_in;
   logic [CNT_W-1:0]  get_done_ff, get_done_in;
   logic              ok_ff, get_ok_ff;

   logic              rsp_valid_ff, rsp_valid_in;

   logic [LIM_W-1:0]  limit;
   logic              add_ok;
   logic              get_ok;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   // acceptance: limit clamps to the store depth
   always_comb begin
      limit  = (LIM_W'(limit_ff) > LIM_DEPTH) ? LIM_DEPTH : LIM_W'(limit_ff);
      add_ok = (req_mode == MODE_ADD) && (LIM_W'(fill_ff) < limit);
      get_ok = (req_mode == MODE_GET) && (fill_ff != '0);
   end

   // queue state and counter updates
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      fill_in     = fill_ff;
      add_try_in  = add_try_ff;
      get_try_in  = get_try_ff;
      add_done_in = add_done_ff;
      get_done_in = get_done_ff;
      if (cmd.take) begin
         if (req_mode == MODE_ADD) begin
            add_try_in = sat_inc(add_try_ff);
         end else begin
            get_try_in = sat_inc(get_try_ff);
         end
         if (add_ok) begin
            tail_in     = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
            fill_in     = fill_ff + 1'b1;
            add_done_in = sat_inc(add_done_ff);
         end
         if (get_ok) begin
            head_in     = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
            fill_in     = fill_ff - 1'b1;
            get_done_in = sat_inc(get_done_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= LIM_RESET;
         head_ff     <= '0;
         tail_ff     <= '0;
         fill_ff     <= '0;
         add_try_ff  <= '0;
         get_try_ff  <= '0;
         add_done_ff <= '0;
         get_done_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         fill_ff     <= fill_in;
         add_try_ff  <= add_try_in;
         get_try_ff  <= get_try_in;
         add_done_ff <= add_done_in;
         get_done_ff <= get_done_in;
      end
   end

   // store write at tail, read at head, outcome flags
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         if (add_ok) begin
            ring_mem[tail_ff] <= req_data_in;
         end
         rd_data_ff <= ring_mem[head_ff];
         ok_ff      <= add_ok | get_ok;
         get_ok_ff  <= get_ok;
      end
   end

   // result register
   assign stat.rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_chan.accepted  <= ok_ff;
         rsp_chan.data_out  <= get_ok_ff ? rd_data_ff : '0;
         rsp_chan.occupancy <= OCC_W'(fill_ff);
         rsp_chan.add_tries <= add_try_ff;
         rsp_chan.get_tries <= get_try_ff;
         rsp_chan.adds_done <= add_done_ff;
         rsp_chan.gets_done <= get_done_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;

endmodule

### hdl/bounded_fifo_with_stats.sv
// ---------------------------------------------------------------------------
// bounded_fifo_with_stats: bounded FIFO queue with usage counters
// Request words add a value to the queue or get the oldest one back; each
// request gives one response word with the outcome and the statistics.
//
// req_chan carries mode (0 add, 1 get) and data_in. rsp_chan returns
// accepted, data_out (0 unless a get succeeded), occupancy after the word
// and four saturating counters: add and get attempts, adds and gets done.
// csr_wr_en/csr_wr_data write the occupancy limit; a limit above the store
// depth acts as the depth. Write it only while no request is outstanding.
// The take registers the outcome and the ring store read; the load of the
// result register then makes the response word valid, and waits while an
// earlier response is still held there. A new request is not taken until
// the response of the last one has been loaded into the result register.
// The next request is taken while an earlier response still waits, so a
// stalled receiver holds the block at one word in flight plus one waiting.
// Reset empties the queue, clears the counters and sets the limit to 1024;
// the ring store itself is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
module bounded_fifo_with_stats import bfs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   bfs_req_if.sink          req_chan,
   bfs_rsp_if.source        rsp_chan,
   input  logic             csr_wr_en,
   input  logic [OCC_W-1:0] csr_wr_data
);

   bfs_cmd_type  cmd;
   bfs_stat_type stat;

   // request sequencing
   bfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // queue storage and statistics
   bfs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_mode    (req_chan.mode),
      .req_data_in (req_chan.data_in),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_chan    (rsp_chan)
   );

endmodule

### bench/tb.sv
// ---------------------------------------------------------------------------
// tb: testbench for bounded_fifo_with_stats
// Sends add and get words under a range of occupancy limits and handshake
// idling. A queue model predicts each response word, and the responses are
// compared with the predictions field by field, in order.
// ---------------------------------------------------------------------------
module tb import bfs_pkg::*; ();

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;

   // one response word as the model predicts it
   typedef struct packed {
      logic              accepted;
      logic [DATA_W-1:0] data_out;
      logic [OCC_W-1:0]  occupancy;
      logic [CNT_W-1:0]  add_tries;
      logic [CNT_W-1:0]  get_tries;
      logic [CNT_W-1:0]  adds_done;
      logic [CNT_W-1:0]  gets_done;
   } outcome_type;

   // queue model plus the responses still owed by the block
   class fifo_scoreboard;
      logic [DATA_W-1:0] ring [DEPTH];
      int unsigned       head, tail, fill, limit;
      logic [CNT_W-1:0]  add_try_cnt, get_try_cnt, add_done_cnt, get_done_cnt;
      outcome_type       owed_q [$];
      int                errors;

      function new();
         head         = 0;
         tail         = 0;
         fill         = 0;
         limit        = (1024 > DEPTH) ? DEPTH : 1024;
         add_try_cnt  = '0;
         get_try_cnt  = '0;
         add_done_cnt = '0;
         get_done_cnt = '0;
         errors       = 0;
      endfunction

      // a limit above the store depth behaves as the depth
      function void set_limit(logic [OCC_W-1:0] value);
         limit = (value > DEPTH) ? DEPTH : value;
      endfunction

      function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] count);
         return (count == '1) ? count : count + 1'b1;
      endfunction

      function void note_request(logic mode, logic [DATA_W-1:0] value);
         outcome_type o;
         o          = '0;
         if (mode == MODE_ADD) begin
            add_try_cnt = bump(add_try_cnt);
            if (fill < limit) begin
               ring[tail]   = value;
               tail         = (tail + 1) % DEPTH;
               fill++;
               add_done_cnt = bump(add_done_cnt);
               o.accepted   = 1'b1;
            end
         end else begin
            get_try_cnt = bump(get_try_cnt);
            if (fill != 0) begin
               o.data_out   = ring[head];
               head         = (head + 1) % DEPTH;
               fill--;
               get_done_cnt = bump(get_done_cnt);
               o.accepted   = 1'b1;
            end
         end
         o.occupancy = OCC_W'(fill);
         o.add_tries = add_try_cnt;
         o.get_tries = get_try_cnt;
         o.adds_done = add_done_cnt;
         o.gets_done = get_done_cnt;
         owed_q.push_back(o);
      endfunction

      function void compare_field(string name, logic [CNT_W-1:0] want,
                                  logic [CNT_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(outcome_type got);
         outcome_type want;
         if (owed_q.size() == 0) begin
            $display("%0t: response word with nothing expected", $time);
            errors++;
            return;
         end
         want = owed_q.pop_front();
         compare_field("accepted",  CNT_W'(want.accepted),  CNT_W'(got.accepted));
         compare_field("data_out",  want.data_out,          got.data_out);
         compare_field("occupancy", CNT_W'(want.occupancy), CNT_W'(got.occupancy));
         compare_field("add_tries", want.add_tries,         got.add_tries);
         compare_field("get_tries", want.get_tries,         got.get_tries);
         compare_field("adds_done", want.adds_done,         got.adds_done);
         compare_field("gets_done", want.gets_done,         got.gets_done);
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [OCC_W-1:0] csr_wr_data;

   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               hold_len      = 0;
   int               hold_seq      = 0;
   int               hold_seen     = 0;
   int               stall_cycles  = 0;
   int               quiet_cycles  = 0;
   fifo_scoreboard   sb;

   bfs_req_if req_bus ();
   bfs_rsp_if rsp_bus ();

   bounded_fifo_with_stats uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: checks each taken word, then picks ready for the next cycle
   always @(posedge clock) begin
      outcome_type got;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.accepted  = rsp_bus.accepted;
            got.data_out  = rsp_bus.data_out;
            got.occupancy = rsp_bus.occupancy;
            got.add_tries = rsp_bus.add_tries;
            got.get_tries = rsp_bus.get_tries;
            got.adds_done = rsp_bus.adds_done;
            got.gets_done = rsp_bus.gets_done;
            sb.check_response(got);
         end
         // pick up a newly requested hold-off
         if (hold_seen != hold_seq) begin
            hold_seen    = hold_seq;
            stall_cycles = hold_len;
         end
         // a long hold-off backs the block up into the request channel
         if (stall_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_cycles--;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // mostly random values, with the extremes mixed in
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0: begin
            return 32'h8000_0000;
         end
         1: begin
            return 32'h7fff_ffff;
         end
         2: begin
            return '0;
         end
         3: begin
            return '1;
         end
         default: begin
            return $urandom();
         end
      endcase
   endfunction

   // offer one request word and return at the edge that takes it
   task automatic send_word(logic mode, logic [DATA_W-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.mode    <= mode;
      req_bus.data_in <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(mode, value);
   endtask

   // stop sending and wait for every owed response, plus the pipeline tail
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.owed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(logic [OCC_W-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.set_limit(value);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_phase(logic [OCC_W-1:0] value, int words, int add_pct, int hold);
      write_limit(value);
      hold_len = hold;
      hold_seq++;
      repeat (words) begin
         send_word(($urandom_range(0, 99) < add_pct) ? MODE_ADD : MODE_GET, pick_value());
      end
   endtask

   initial begin
      sb = new();
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.mode    <= MODE_ADD;
      req_bus.data_in <= '0;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= '0;
      send_idle_pct    = 11;
      recv_idle_pct    = 46;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset limit: get from empty, then the data extremes in and out again
      send_word(MODE_GET, 32'h1234_5678);
      send_word(MODE_ADD, 32'h7fff_ffff);
      send_word(MODE_ADD, 32'h8000_0000);
      send_word(MODE_ADD, '0);
      send_word(MODE_ADD, '1);
      repeat (4) send_word(MODE_GET, $urandom());
      send_word(MODE_GET, '1);

      // zero limit refuses every add
      write_limit(11'd0);
      send_word(MODE_ADD, 32'h5a5a_a5a5);
      send_word(MODE_GET, '0);

      // limit of three: the fourth add is refused
      write_limit(11'd3);
      repeat (4) send_word(MODE_ADD, $urandom());

      // limit lowered below the fill: adds refused until gets drain it
      write_limit(11'd1);
      send_word(MODE_ADD, $urandom());
      send_word(MODE_GET, $urandom());
      send_word(MODE_ADD, $urandom());
      send_word(MODE_GET, $urandom());
      send_word(MODE_GET, $urandom());
      send_word(MODE_ADD, $urandom());

      // all-ones limit acts as the depth
      write_limit(11'h7ff);
      send_word(MODE_GET, $urandom());

      // random words: sender idles lightly, receiver heavily
      run_phase(11'd5, 130, 55, 0);
      run_phase(11'd1, 80, 50, 0);

      // roles swapped, with a long receiver hold-off
      send_idle_pct = 46;
      recv_idle_pct = 11;
      run_phase(11'd1024, 120, 50, 60);
      run_phase(11'd17, 120, 60, 0);

      // no random idling, one receiver hold-off: fill to the depth, then refuse and drain
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(11'h7ff, 1060, 98, 80);
      run_phase(11'd1025, 60, 70, 0);
      run_phase(11'd0, 150, 40, 0);

      settle();
      if (sb.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
